// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tbpl_pkg.sv =====
`default_nettype none
package tbpl_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DIVN_W    = 88;
  localparam int DIVD_W    = 100;
  localparam int DIVR_W    = 101;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int S3_W      = 99;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  localparam logic CFG_MASS_FIRST  = 1'b0;
  localparam logic CFG_MASS_SECOND = 1'b1;

  typedef struct packed {
    logic signed [31:0] eccentricity;
    logic signed [31:0] peri_separation;
    logic signed [31:0] time_to_peri;
    logic [15:0]        step_count;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // magnitude, saturated to the signed 32-bit range, then signed
  function automatic sat_t clamp_mag(input logic [DIVN_W-1:0] m, input logic neg);
    sat_t r;
    logic [DIVN_W-1:0] lim;
    lim = neg ? DIVN_W'(33'h0_8000_0000) : DIVN_W'(32'h7FFF_FFFF);
    r.ovf = (m > lim);
    r.val = r.ovf ? lim[31:0] : m[31:0];
    if (neg) r.val = -r.val;
    return r;
  endfunction

  function automatic sat_t sat32(input logic [32:0] x);
    sat_t r;
    r.ovf = (x[32] != x[31]);
    if (r.ovf) r.val = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r.val = x[31:0];
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] x);
    return x[32] ? 33'(-x) : x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tbpl_if.sv =====
`default_nettype none
interface tbpl_req_if;
  logic          valid;
  logic          ready;
  tbpl_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbpl_rsp_if;
  logic          valid;
  logic          ready;
  tbpl_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/two_body_pericenter_leapfrog_backstep.sv =====
// Two-body pericenter set-up with backward kick-drift-kick leapfrog, signed Q8.24, masses Q7.24.
// One request is worked at a time: req.ready is high only while the block is idle and no
// result waits on rsp. Multiplies, divides and roots share a registered 33x33 multiplier
// and a bit-serial divide / square-root datapath. Divides dominate the run time: set-up runs
// seven and each leapfrog step runs eight.
// Invalid requests answer in the cycle after acceptance. A mass register takes cfg_data on
// any cycle with cfg_we high, so write the masses only while idle.
`default_nettype none
`include "assert_macros.svh"
module two_body_pericenter_leapfrog_backstep (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data,
  tbpl_req_if.sink         req,
  tbpl_rsp_if.source       rsp
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_VQ_MUL   = 5'd1;
  localparam logic [4:0] S_VQ_DIV0  = 5'd2;
  localparam logic [4:0] S_VQ_SQ0   = 5'd3;
  localparam logic [4:0] S_VP       = 5'd4;
  localparam logic [4:0] S_INIT_MUL = 5'd5;
  localparam logic [4:0] S_INIT_DV0 = 5'd6;
  localparam logic [4:0] S_INIT_ST  = 5'd7;
  localparam logic [4:0] S_DT0      = 5'd8;
  localparam logic [4:0] S_DT_ST    = 5'd9;
  localparam logic [4:0] S_DIV      = 5'd10;
  localparam logic [4:0] S_SQRT     = 5'd11;
  localparam logic [4:0] S_G_DX     = 5'd12;
  localparam logic [4:0] S_G_SQX    = 5'd13;
  localparam logic [4:0] S_G_SQY    = 5'd14;
  localparam logic [4:0] S_G_SUM    = 5'd15;
  localparam logic [4:0] S_G_S      = 5'd16;
  localparam logic [4:0] S_G_S2     = 5'd17;
  localparam logic [4:0] S_G_S3A    = 5'd18;
  localparam logic [4:0] S_G_S3B    = 5'd19;
  localparam logic [4:0] S_G_S3C    = 5'd20;
  localparam logic [4:0] S_G_NMUL   = 5'd21;
  localparam logic [4:0] S_G_NDV0   = 5'd22;
  localparam logic [4:0] S_G_NST    = 5'd23;
  localparam logic [4:0] S_K_MUL    = 5'd24;
  localparam logic [4:0] S_K_ADD    = 5'd25;
  localparam logic [4:0] S_D_MUL    = 5'd26;
  localparam logic [4:0] S_D_ADD    = 5'd27;
  localparam logic [4:0] S_DONE     = 5'd28;

  localparam logic [6:0] DIV_LAST  = 7'(tbpl_pkg::DIVN_W - 1);
  localparam logic [6:0] SQRT_LAST = 7'(tbpl_pkg::DIVN_W / 2 - 1);
  localparam logic [32:0] ONE_Q    = 33'(1) << tbpl_pkg::FRAC_BITS;

  logic [4:0]  state;
  logic [4:0]  ret;
  logic [30:0] mass_first;
  logic [30:0] mass_second;
  logic [31:0] mtot;
  logic signed [31:0] ecc;
  logic signed [31:0] rp;
  logic signed [31:0] tp;
  logic [15:0] n;
  logic [15:0] k;
  logic        phase;
  logic [1:0]  idx;
  logic        ovf;
  logic        inv;
  logic [31:0] vp;
  logic signed [31:0] dt;
  logic signed [31:0] half;
  logic [31:0] pos [4];
  logic [31:0] vel [4];
  logic [31:0] acc [4];
  logic [32:0] dx;
  logic [32:0] dy;
  logic [65:0] sumsq;
  logic [32:0] s;
  logic [32:0] s2hi;
  logic [tbpl_pkg::S3_W-1:0] s3;

  logic [tbpl_pkg::MUL_W-1:0]  mul_a;
  logic [tbpl_pkg::MUL_W-1:0]  mul_b;
  logic [tbpl_pkg::PROD_W-1:0] prod;

  logic [tbpl_pkg::DIVN_W-1:0] div_n;
  logic [tbpl_pkg::DIVD_W-1:0] div_d;
  logic [tbpl_pkg::DIVR_W-1:0] div_r;
  logic [tbpl_pkg::DIVN_W-1:0] div_q;
  logic [6:0]                  cnt;

  logic [tbpl_pkg::DIVR_W-1:0] sh_val;
  logic [tbpl_pkg::DIVR_W-1:0] sub_op;
  logic [tbpl_pkg::DIVR_W-1:0] sub_res;
  logic                        sub_ge;

  logic [32:0] mtot_w;
  logic        bad_req;
  logic [32:0] d_sel;
  logic        neg_sel;
  tbpl_pkg::sat_t c_q;
  tbpl_pkg::sat_t c_f;
  tbpl_pkg::sat_t c_s;
  logic [31:0] fmul_a;
  logic [31:0] upd_base;

  assign mtot_w  = 33'(mass_first) + 33'(mass_second);
  assign bad_req = (req.data.peri_separation == '0) || req.data.eccentricity[31] ||
                   (req.data.step_count == '0) || (mtot_w == '0);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.data.pos_a_x = pos[0];
  assign rsp.data.pos_a_y = pos[1];
  assign rsp.data.pos_b_x = pos[2];
  assign rsp.data.pos_b_y = pos[3];
  assign rsp.data.vel_a_x = vel[0];
  assign rsp.data.vel_a_y = vel[1];
  assign rsp.data.vel_b_x = vel[2];
  assign rsp.data.vel_b_y = vel[3];
  assign rsp.data.status  = inv ? tbpl_pkg::ST_INVALID :
                            (ovf ? tbpl_pkg::ST_OVF : tbpl_pkg::ST_OK);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_VQ_MUL: begin
        mul_a = 33'({1'b0, ecc}) + ONE_Q;
        mul_b = 33'(mtot);
      end
      S_INIT_MUL: begin
        mul_a = idx[1] ? 33'(vp) : tbpl_pkg::mag33({rp[31], rp});
        mul_b = idx[0] ? 33'(mass_first) : 33'(mass_second);
      end
      S_G_SQX: begin
        mul_a = tbpl_pkg::mag33(dx);
        mul_b = tbpl_pkg::mag33(dx);
      end
      S_G_SQY: begin
        mul_a = tbpl_pkg::mag33(dy);
        mul_b = tbpl_pkg::mag33(dy);
      end
      S_G_S2: begin
        mul_a = s;
        mul_b = s;
      end
      S_G_S3A: begin
        mul_a = prod[32:0];
        mul_b = s;
      end
      S_G_S3B: begin
        mul_a = s2hi;
        mul_b = s;
      end
      S_G_NMUL: begin
        mul_a = tbpl_pkg::mag33(idx[0] ? dy : dx);
        mul_b = idx[1] ? 33'(mass_first) : 33'(mass_second);
      end
      S_K_MUL: begin
        mul_a = tbpl_pkg::mag33({acc[idx][31], acc[idx]});
        mul_b = tbpl_pkg::mag33({half[31], half});
      end
      S_D_MUL: begin
        mul_a = tbpl_pkg::mag33({vel[idx][31], vel[idx]});
        mul_b = tbpl_pkg::mag33({dt[31], dt});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared subtract / compare for divide and root steps
  always_comb begin
    if (state == S_SQRT) begin
      sh_val = {div_r[tbpl_pkg::DIVR_W-3:0], div_n[tbpl_pkg::DIVN_W-1 -: 2]};
      sub_op = tbpl_pkg::DIVR_W'({div_q[43:0], 2'b01});
    end else begin
      sh_val = {div_r[tbpl_pkg::DIVR_W-2:0], div_n[tbpl_pkg::DIVN_W-1]};
      sub_op = {1'b0, div_d};
    end
    sub_res = sh_val - sub_op;
    sub_ge  = (sh_val >= sub_op);
  end

  // clamp of the current quotient or root, with the sign of the slot being filled
  always_comb begin
    d_sel   = idx[0] ? dy : dx;
    neg_sel = 1'b0;
    case (state)
      S_INIT_ST: begin
        case (idx)
          2'd0:    neg_sel = rp[31];
          2'd1:    neg_sel = !rp[31];
          2'd2:    neg_sel = 1'b1;
          default: neg_sel = 1'b0;
        endcase
      end
      S_DT_ST: neg_sel = !tp[31] && (tp != '0);
      S_G_NST: neg_sel = idx[1] ? d_sel[32] : (!d_sel[32] && (d_sel != '0));
      default: neg_sel = 1'b0;
    endcase
    c_q = tbpl_pkg::clamp_mag(div_q, neg_sel);
  end

  // fixed-point product and saturating update for kick and drift
  always_comb begin
    if (state == S_K_ADD) begin
      fmul_a   = acc[idx];
      upd_base = vel[idx];
      c_f = tbpl_pkg::clamp_mag(
              tbpl_pkg::DIVN_W'(prod >> tbpl_pkg::FRAC_BITS), fmul_a[31] != half[31]);
    end else begin
      fmul_a   = vel[idx];
      upd_base = pos[idx];
      c_f = tbpl_pkg::clamp_mag(
              tbpl_pkg::DIVN_W'(prod >> tbpl_pkg::FRAC_BITS), fmul_a[31] != dt[31]);
    end
    c_s = tbpl_pkg::sat32({upd_base[31], upd_base} + {c_f.val[31], c_f.val});
  end

  always_ff @(posedge clk) begin
    prod <= tbpl_pkg::PROD_W'(mul_a) * tbpl_pkg::PROD_W'(mul_b);
    if (rst) begin
      state       <= S_IDLE;
      mass_first  <= 31'd20971520;
      mass_second <= 31'd20971520;
      ovf         <= 1'b0;
      inv         <= 1'b0;
      idx         <= '0;
      phase       <= 1'b0;
      k           <= '0;
      cnt         <= '0;
      ret         <= S_IDLE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbpl_pkg::CFG_MASS_FIRST:  mass_first  <= cfg_data;
          tbpl_pkg::CFG_MASS_SECOND: mass_second <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            ecc  <= req.data.eccentricity;
            rp   <= req.data.peri_separation;
            tp   <= req.data.time_to_peri;
            n    <= req.data.step_count;
            mtot <= mtot_w[31:0];
            idx  <= '0;
            ovf  <= 1'b0;
            inv  <= bad_req;
            for (int i = 0; i < 4; i++) begin
              pos[i] <= '0;
              vel[i] <= '0;
            end
            state <= bad_req ? S_DONE : S_VQ_MUL;
          end
        end
        S_VQ_MUL: state <= S_VQ_DIV0;
        S_VQ_DIV0: begin
          div_n <= tbpl_pkg::DIVN_W'(prod);
          div_d <= tbpl_pkg::DIVD_W'(tbpl_pkg::mag33({rp[31], rp}));
          div_r <= '0;
          div_q <= '0;
          cnt   <= DIV_LAST;
          ret   <= S_VQ_SQ0;
          state <= S_DIV;
        end
        S_VQ_SQ0: begin
          div_n <= div_q << tbpl_pkg::FRAC_BITS;
          div_r <= '0;
          div_q <= '0;
          cnt   <= SQRT_LAST;
          ret   <= S_VP;
          state <= S_SQRT;
        end
        S_VP: begin
          vp    <= c_q.val;
          ovf   <= ovf | c_q.ovf;
          idx   <= '0;
          state <= S_INIT_MUL;
        end
        S_INIT_MUL: state <= S_INIT_DV0;
        S_INIT_DV0: begin
          div_n <= tbpl_pkg::DIVN_W'(prod);
          div_d <= tbpl_pkg::DIVD_W'(mtot);
          div_r <= '0;
          div_q <= '0;
          cnt   <= DIV_LAST;
          ret   <= S_INIT_ST;
          state <= S_DIV;
        end
        S_INIT_ST: begin
          ovf <= ovf | c_q.ovf;
          case (idx)
            2'd0:    pos[0] <= c_q.val;
            2'd1:    pos[2] <= c_q.val;
            2'd2:    vel[1] <= c_q.val;
            default: vel[3] <= c_q.val;
          endcase
          idx   <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_DT0 : S_INIT_MUL;
        end
        S_DT0: begin
          div_n <= tbpl_pkg::DIVN_W'(tbpl_pkg::mag33({tp[31], tp}));
          div_d <= idx[0] ? tbpl_pkg::DIVD_W'({n, 1'b0}) : tbpl_pkg::DIVD_W'(n);
          div_r <= '0;
          div_q <= '0;
          cnt   <= DIV_LAST;
          ret   <= S_DT_ST;
          state <= S_DIV;
        end
        S_DT_ST: begin
          ovf <= ovf | c_q.ovf;
          if (idx[0]) begin
            half  <= c_q.val;
            idx   <= '0;
            k     <= '0;
            phase <= 1'b0;
            state <= S_G_DX;
          end else begin
            dt    <= c_q.val;
            idx   <= 2'd1;
            state <= S_DT0;
          end
        end
        S_DIV, S_SQRT: begin
          if (state == S_SQRT) div_n <= div_n << 2;
          else div_n <= div_n << 1;
          div_r <= sub_ge ? sub_res : sh_val;
          div_q <= {div_q[tbpl_pkg::DIVN_W-2:0], sub_ge};
          cnt   <= cnt - 7'd1;
          if (cnt == '0) state <= ret;
        end
        S_G_DX: begin
          dx    <= {pos[0][31], pos[0]} - {pos[2][31], pos[2]};
          dy    <= {pos[1][31], pos[1]} - {pos[3][31], pos[3]};
          state <= S_G_SQX;
        end
        S_G_SQX: state <= S_G_SQY;
        S_G_SQY: begin
          sumsq <= prod;
          state <= S_G_SUM;
        end
        S_G_SUM: begin
          div_n <= tbpl_pkg::DIVN_W'(sumsq) + tbpl_pkg::DIVN_W'(prod);
          div_r <= '0;
          div_q <= '0;
          cnt   <= SQRT_LAST;
          ret   <= S_G_S;
          state <= S_SQRT;
        end
        S_G_S: begin
          idx <= '0;
          if (div_q == '0) begin
            for (int i = 0; i < 4; i++) acc[i] <= '0;
            ovf   <= 1'b1;
            state <= S_K_MUL;
          end else begin
            s     <= div_q[32:0];
            state <= S_G_S2;
          end
        end
        S_G_S2: state <= S_G_S3A;
        S_G_S3A: begin
          s2hi  <= prod[65:33];
          state <= S_G_S3B;
        end
        S_G_S3B: begin
          s3    <= tbpl_pkg::S3_W'(prod);
          state <= S_G_S3C;
        end
        S_G_S3C: begin
          s3    <= s3 + (tbpl_pkg::S3_W'(prod) << 33);
          idx   <= '0;
          state <= S_G_NMUL;
        end
        S_G_NMUL: state <= S_G_NDV0;
        S_G_NDV0: begin
          div_n <= tbpl_pkg::DIVN_W'(prod) << tbpl_pkg::FRAC_BITS;
          div_d <= tbpl_pkg::DIVD_W'(s3);
          div_r <= '0;
          div_q <= '0;
          cnt   <= DIV_LAST;
          ret   <= S_G_NST;
          state <= S_DIV;
        end
        S_G_NST: begin
          acc[idx] <= c_q.val;
          ovf      <= ovf | c_q.ovf;
          idx      <= idx + 2'd1;
          state    <= (idx == 2'd3) ? S_K_MUL : S_G_NMUL;
        end
        S_K_MUL: state <= S_K_ADD;
        S_K_ADD: begin
          vel[idx] <= c_s.val;
          ovf      <= ovf | c_f.ovf | c_s.ovf;
          idx      <= idx + 2'd1;
          if (idx != 2'd3) begin
            state <= S_K_MUL;
          end else if (!phase) begin
            state <= S_D_MUL;
          end else begin
            phase <= 1'b0;
            k     <= k + 16'd1;
            state <= (k == n - 16'd1) ? S_DONE : S_G_DX;
          end
        end
        S_D_MUL: state <= S_D_ADD;
        S_D_ADD: begin
          pos[idx] <= c_s.val;
          ovf      <= ovf | c_f.ovf | c_s.ovf;
          idx      <= idx + 2'd1;
          if (idx == 2'd3) begin
            phase <= 1'b1;
            state <= S_G_DX;
          end else begin
            state <= S_D_MUL;
          end
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_ready_no_result, req.ready, !rsp.valid, "input taken while a result waits")
  `ASSERT_NXT(a_invalid_fast, req.valid && req.ready && req.data.step_count == '0, rsp.valid && rsp.data.status == tbpl_pkg::ST_INVALID, "zero step count not flagged")
  `ASSERT_NXT(a_unit_busy, (state == S_DIV || state == S_SQRT) && cnt != '0, state == $past(state), "shared unit left early")

endmodule
`default_nettype wire
